// ===== rtl/rcfd_pkg.sv =====
// Shared types and constants of the remote-receiver frame decoder.
package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int STICK_COUNT = 5;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int VAL_DEPTH   = 19;
  localparam int VAL_AW      = $clog2(VAL_DEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0]  ONLINE_RELOAD   = 8'hFA;
  localparam logic [7:0]  OFFLINE_LIMIT   = 8'h32;
  localparam logic [10:0] OFFSET_RESET    = 11'd1024;
  localparam logic [10:0] DEADZONE_RESET  = 11'd10;

  // operation codes
  localparam logic [1:0] OP_BYTE     = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_ACTIVITY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd1;

  // result field ids
  localparam logic [4:0] ID_STICK0  = 5'd0;
  localparam logic [4:0] ID_STICK1  = 5'd1;
  localparam logic [4:0] ID_STICK2  = 5'd2;
  localparam logic [4:0] ID_STICK3  = 5'd3;
  localparam logic [4:0] ID_STICK4  = 5'd4;
  localparam logic [4:0] ID_SWITCH0 = 5'd5;
  localparam logic [4:0] ID_SWITCH1 = 5'd6;
  localparam logic [4:0] ID_MOUSE0  = 5'd7;
  localparam logic [4:0] ID_MOUSE1  = 5'd8;
  localparam logic [4:0] ID_MOUSE2  = 5'd9;
  localparam logic [4:0] ID_BUTTON0 = 5'd10;
  localparam logic [4:0] ID_BUTTON1 = 5'd11;
  localparam logic [4:0] ID_KEY     = 5'd12;
  localparam logic [4:0] ID_STATUS  = 5'd13;
  localparam logic [4:0] ID_TIME0   = 5'd14;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  frame_byte;
    logic        frame_start;
    logic [31:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic        link_lost;
    logic [4:0]  active_mask;
    logic        last_of_run;
  } out_item_t;

  // value store access for one cycle
  typedef struct packed {
    logic              we;
    logic [VAL_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [VAL_AW-1:0] raddr;
    logic              clr;
  } vm_req_t;

endpackage

// ===== rtl/rc_receiver_frame_decoder_top.sv =====
// Top level of the remote-receiver frame decoder: byte buffer, sequencer, output register.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_stall   | in_data  (rcfd_pkg::in_item_t)
//   out_    | out       | out_valid / out_stall | out_data (rcfd_pkg::out_item_t)
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A frame byte that does not end a frame leaves the sequencer idle, so bytes may follow
// every cycle. The last byte reads the other 17 back from the byte buffer, one per cycle,
// then issues 14 results, one per cycle while out_stall is low. An activity check scans
// the sticks, then gives 5 results, each read through the single read port of the value
// store in S_TRD and issued in S_TOUT. No clearing pass after reset: the value store
// clears its valid bits at once. out_stall holds the output register and the issuing
// states; the input is held off whenever the sequencer is not idle.
module rc_receiver_frame_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rcfd_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rcfd_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [10:0]                       cfg_data
);
  import rcfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_FRAME, S_TICK, S_SCAN, S_TRD, S_TOUT
  } state_t;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  state_t            state_r;
  logic [4:0]        cnt_r;
  logic [POS_W-1:0]  pos_r;
  logic [7:0]        online_r;
  logic              lost_r;
  logic [4:0]        act_r;
  logic [31:0]       ts_r;
  logic [10:0]       offset_r;
  logic [10:0]       deadzone_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [7:0]        bmem [FRAME_BYTES];
  logic [7:0]        bmem_q_r;
  logic [7:0]        fr_r [FRAME_BYTES];

  logic              in_acc;
  logic              slot_free;
  logic              out_load;
  logic [POS_W-1:0]  pos_eff;
  logic              tick_clear;
  logic [10:0]       raw11;
  logic [15:0]       stick_diff;
  logic [31:0]       frame_val;
  logic [15:0]       stick_v;
  logic [16:0]       stick_mag;
  logic              stick_act;
  logic [2:0]        scan_idx;
  logic [31:0]       vm_rd;
  vm_req_t           vm_req;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  // a result is loaded into the output register this cycle
  assign out_load  = slot_free &&
                     (state_r == S_FRAME || state_r == S_TICK || state_r == S_TOUT);
  assign pos_eff   = in_data.frame_start ? '0 : pos_r;
  assign tick_clear = (online_r <= OFFLINE_LIMIT);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // byte buffer
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_BYTE) begin
      bmem[pos_eff] <= in_data.frame_byte;
    end
    if (state_r == S_LOAD && cnt_r[POS_W-1:0] != LAST_POS) begin
      bmem_q_r <= bmem[cnt_r[POS_W-1:0]];
    end
  end

  // raw stick channel for the field being issued
  always_comb begin
    raw11 = '0;
    unique case (cnt_r)
      ID_STICK0: raw11 = {fr_r[1][2:0], fr_r[0]};
      ID_STICK1: raw11 = {fr_r[2][5:0], fr_r[1][7:3]};
      ID_STICK2: raw11 = {fr_r[4][0], fr_r[3], fr_r[2][7:6]};
      ID_STICK3: raw11 = {fr_r[5][3:0], fr_r[4][7:1]};
      ID_STICK4: raw11 = {fr_r[17][2:0], fr_r[16]};
      default:   raw11 = '0;
    endcase
  end

  assign stick_diff = {5'b0, raw11} - {5'b0, offset_r};

  always_comb begin
    frame_val = '0;
    unique case (cnt_r)
      ID_STICK0, ID_STICK1, ID_STICK2, ID_STICK3, ID_STICK4:
                  frame_val = {16'b0, stick_diff};
      ID_SWITCH0: frame_val = {30'b0, fr_r[5][7:6]};
      ID_SWITCH1: frame_val = {30'b0, fr_r[5][5:4]};
      ID_MOUSE0:  frame_val = {16'b0, fr_r[7], fr_r[6]};
      ID_MOUSE1:  frame_val = {16'b0, fr_r[9], fr_r[8]};
      ID_MOUSE2:  frame_val = {16'b0, fr_r[11], fr_r[10]};
      ID_BUTTON0: frame_val = {24'b0, fr_r[12]};
      ID_BUTTON1: frame_val = {24'b0, fr_r[13]};
      ID_KEY:     frame_val = {16'b0, fr_r[15], fr_r[14]};
      ID_STATUS:  frame_val = {24'b0, online_r};
      default:    frame_val = '0;
    endcase
  end

  // stick magnitude against the deadzone, on data read in the previous cycle
  assign stick_v   = vm_rd[15:0];
  assign stick_mag = stick_v[15] ? (17'h10000 - {1'b0, stick_v}) : {1'b0, stick_v};
  assign stick_act = (stick_mag >= {6'b0, deadzone_r});
  assign scan_idx  = 3'(cnt_r - 5'd1);

  always_comb begin
    vm_req = '0;
    unique case (state_r)
      S_IDLE: begin
        vm_req.clr = in_acc && in_data.operation == OP_TICK && tick_clear;
      end
      S_FRAME: begin
        if (slot_free && cnt_r <= ID_KEY) begin
          vm_req.we    = 1'b1;
          vm_req.waddr = cnt_r;
          vm_req.wdata = frame_val;
        end
      end
      S_SCAN: begin
        if (cnt_r < 5'(STICK_COUNT)) begin
          vm_req.re    = 1'b1;
          vm_req.raddr = cnt_r;
        end
        if (cnt_r != 5'd0 && stick_act) begin
          vm_req.we    = 1'b1;
          vm_req.waddr = ID_TIME0 + cnt_r - 5'd1;
          vm_req.wdata = ts_r;
        end
      end
      S_TRD: begin
        vm_req.re    = 1'b1;
        vm_req.raddr = ID_TIME0 + cnt_r;
      end
      default: vm_req = '0;
    endcase
  end

  rcfd_valmem u_valmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (vm_req),
    .rd_data (vm_rd)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= OFFSET_RESET;
      deadzone_r <= DEADZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET:   offset_r   <= cfg_data;
        CFG_DEADZONE: deadzone_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack register, filled from the byte buffer read-back and, for the last byte, from the input
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_BYTE && pos_eff == LAST_POS) begin
      fr_r[FRAME_BYTES-1] <= in_data.frame_byte;
    end
    if (state_r == S_LOAD && cnt_r != 5'd0) begin
      fr_r[POS_W'(cnt_r - 5'd1)] <= bmem_q_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      online_r    <= ONLINE_RELOAD;
      lost_r      <= 1'b1;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_load && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            priority case (in_data.operation)
              OP_BYTE: begin
                if (pos_eff == LAST_POS) begin
                  pos_r    <= '0;
                  online_r <= ONLINE_RELOAD;
                  lost_r   <= 1'b0;
                  state_r  <= S_LOAD;
                end else begin
                  pos_r <= pos_eff + 1'b1;
                end
              end
              OP_TICK: begin
                if (tick_clear) begin
                  online_r <= '0;
                  lost_r   <= 1'b1;
                  act_r    <= '0;
                end else begin
                  online_r <= online_r - 8'd1;
                end
                state_r <= S_TICK;
              end
              OP_ACTIVITY: begin
                ts_r    <= in_data.time_stamp;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          if (cnt_r[POS_W-1:0] == LAST_POS) begin
            cnt_r   <= '0;
            state_r <= S_FRAME;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_FRAME: begin
          if (slot_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.field_id     <= cnt_r;
            out_data_r.field_value  <= frame_val;
            out_data_r.link_lost    <= lost_r;
            out_data_r.active_mask  <= act_r;
            out_data_r.last_of_run  <= (cnt_r == ID_STATUS);
            if (cnt_r == ID_STATUS) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        S_TICK: begin
          if (slot_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.field_id     <= ID_STATUS;
            out_data_r.field_value  <= {24'b0, online_r};
            out_data_r.link_lost    <= lost_r;
            out_data_r.active_mask  <= act_r;
            out_data_r.last_of_run  <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (cnt_r != 5'd0) begin
            act_r[scan_idx] <= stick_act;
          end
          if (cnt_r == 5'(STICK_COUNT)) begin
            cnt_r   <= '0;
            state_r <= S_TRD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_TRD: begin
          state_r <= S_TOUT;
        end
        S_TOUT: begin
          if (slot_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.field_id     <= ID_TIME0 + cnt_r;
            out_data_r.field_value  <= vm_rd;
            out_data_r.link_lost    <= lost_r;
            out_data_r.active_mask  <= act_r;
            out_data_r.last_of_run  <= (cnt_r == 5'(STICK_COUNT - 1));
            if (cnt_r == 5'(STICK_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r + 5'd1;
              state_r <= S_TRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rcfd_valmem.sv =====
// Value store: decoded fields and stick active times, with per-entry valid bits.
module rcfd_valmem (
  input  logic             clk,
  input  logic             rst_n,
  input  rcfd_pkg::vm_req_t req,
  output logic [31:0]      rd_data
);
  import rcfd_pkg::*;

  logic [31:0]          mem [VAL_DEPTH];
  logic [VAL_DEPTH-1:0] valid_r;
  logic [31:0]          rd_q_r;
  logic                 rd_ok_r;

  // the sequencer never reads and writes one entry in the same cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (req.re) begin
      rd_ok_r <= valid_r[req.raddr];
    end
  end

  // an entry not written since reset or the last clear reads as zero
  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ===== rtl/rcfd_checker.sv =====
// Port-level checks on the frame decoder, bound to its top level.
module rcfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rcfd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rcfd_pkg::out_item_t out_data
);
  import rcfd_pkg::*;

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a tick always produces a result, so the input is held off next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_TICK |=> in_stall)
    else $error("input taken while a tick result is pending");

  // a status result always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_id == ID_STATUS |-> out_data.last_of_run)
    else $error("status result not marked last");

  // decoded frame fields fit in 16 bits
  a_field_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_id <= ID_KEY |-> out_data.field_value[31:16] == 16'b0)
    else $error("frame field wider than 16 bits");

endmodule

bind rc_receiver_frame_decoder_top rcfd_checker u_rcfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
